### rtl/tlf_pkg.sv
package tlf_pkg;

    localparam int TAB_SHIFT = 3;          // tab stop of 8 columns
    localparam int MAX_FILL  = 54;         // hold fill limit, keeps the held bytes within 54 words

    localparam logic [7:0] C_TAB = 8'h09;
    localparam logic [7:0] C_BS  = 8'h08;
    localparam logic [7:0] C_CR  = 8'h0D;
    localparam logic [7:0] C_SP  = 8'h20;
    localparam logic [7:0] C_NL  = 8'h0A;

    localparam logic [15:0] WIDTH_RESET = 16'd80;

    localparam logic [1:0] REG_WIDTH       = 2'd0;
    localparam logic [1:0] REG_COUNT_BYTES = 2'd1;
    localparam logic [1:0] REG_BLANKS      = 2'd2;

    typedef struct packed {
        logic       is_end;
        logic       is_nl;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [15:0] line_width;
        logic        count_bytes;
        logic        break_at_blanks;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_CHECK, S_PLAN, S_RD_ADDR, S_RD_DATA,
        S_UNIT, S_NL, S_WR, S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        T_NONE, T_END, T_NL, T_BYTE, T_TU, T_START
    } t_tail;

    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] n;
        begin
            n = 3'd0;
            if (lead >= 8'hC2 && lead <= 8'hDF) n = 3'd2;
            else if (lead >= 8'hE0 && lead <= 8'hEF) n = 3'd3;
            else if (lead >= 8'hF0 && lead <= 8'hF4) n = 3'd4;
            return n;
        end
    endfunction

    function automatic logic fits_next(input logic [7:0] lead, input logic [1:0] pos,
                                       input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        begin
            lo = 8'h80;
            hi = 8'hBF;
            if (pos == 2'd1) begin
                if (lead == 8'hE0) lo = 8'hA0;
                else if (lead == 8'hED) hi = 8'h9F;
                else if (lead == 8'hF0) lo = 8'h90;
                else if (lead == 8'hF4) hi = 8'h8F;
            end
            return (b >= lo) && (b <= hi);
        end
    endfunction

endpackage

### rtl/tlf_if.sv
interface tlf_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface tlf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

### rtl/tlf_ram.sv
module tlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/tlf_front.sv
module tlf_front
    import tlf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    tlf_in_if.sink i_in,
    output logic  o_q_valid,
    output t_item o_q_item,
    input  logic  i_q_pop
);
    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_item      item;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;

    always_comb begin
        item.is_end = i_in.action;
        item.is_nl  = !i_in.action && (i_in.data_byte == C_NL);
        item.data   = i_in.data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= item;
                r_wp      <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];
endmodule

### rtl/tlf_back.sv
module tlf_back
    import tlf_pkg::*;
#(
    parameter int HOLD_DEPTH = 62
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_item     i_q_item,
    output logic      o_q_pop,
    tlf_out_if.source o_out
);
    localparam int HW = $clog2(HOLD_DEPTH + 1);
    localparam int AW = $clog2(HOLD_DEPTH);
    localparam int HOLD_FILL = (HOLD_DEPTH < MAX_FILL) ? HOLD_DEPTH : MAX_FILL;

    t_state      r_state, n_state;
    t_tail       r_tail;
    logic [7:0]  r_b;
    logic [15:0] r_col;
    logic [HW-1:0] r_hcnt;
    logic [HW-1:0] r_hi;
    logic        r_blank;
    logic [7:0]  r_part [3];
    logic [1:0]  r_pcnt;
    logic [1:0]  r_pf_n, r_pf_i;
    logic [7:0]  r_u [4];
    logic [2:0]  r_ulen;
    logic [1:0]  r_ui;
    logic        r_p_flush, r_p_unit, r_p_nl, r_p_rescan, r_p_wr, r_p_mark, r_again;
    logic        r_rescan;
    logic [7:0]  r_rs_lead;
    logic [2:0]  r_rs_n;
    logic [1:0]  r_rs_k;
    logic        r_lag_v;
    logic [7:0]  r_lag_b;
    logic        r_ov, r_ol;
    logic [7:0]  r_ob;

    logic        out_free, can_emit, emit_en, finish_push, ram_we, unit_last;
    logic [7:0]  emit_b, ram_wdata, ram_rdata;
    logic        blanks_on, is_blank, fits_hold;
    logic [16:0] nc;
    logic [15:0] rs_base;
    logic [16:0] rs_nc;

    function automatic logic [16:0] col_step(input logic [15:0] col, input logic [7:0] x,
                                             input logic plain);
        logic [16:0] c;
        begin
            c = {1'b0, col};
            if (plain) return c + 17'd1;
            if (x == C_TAB) return ((c >> TAB_SHIFT) + 17'd1) << TAB_SHIFT;
            if (x == C_BS) return (col != 16'd0) ? c - 17'd1 : 17'd0;
            if (x == C_CR) return 17'd0;
            return c + 17'd1;
        end
    endfunction

    tlf_ram #(.WIDTH(8), .DEPTH(HOLD_DEPTH)) u_hold (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_hcnt[AW-1:0]),
        .i_wdata(ram_wdata),
        .i_raddr(r_hi[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign out_free  = !r_ov || o_out.ready;
    assign can_emit  = !r_lag_v || out_free;
    assign blanks_on = i_cfg.break_at_blanks && !i_cfg.count_bytes;
    assign nc        = col_step(r_col, r_u[0], i_cfg.count_bytes || (r_ulen > 3'd1));
    assign is_blank  = !i_cfg.count_bytes && (r_ulen == 3'd1) &&
                       (r_u[0] == C_SP || r_u[0] == C_TAB);
    assign fits_hold = ({1'b0, r_hcnt} + (HW+1)'(r_ulen)) <= (HW+1)'(HOLD_FILL);
    assign unit_last = ({1'b0, r_ui} + 3'd1) == r_ulen;
    assign rs_base   = (r_rs_k == 2'd0) ? r_col : r_col + 16'(r_rs_k) - 16'd1;
    assign rs_nc     = col_step(rs_base, ram_rdata, i_cfg.count_bytes);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_q_valid) n_state = S_DISPATCH;
            S_DISPATCH: begin
                if (r_pf_i != r_pf_n) begin
                    n_state = S_CHECK;
                end else begin
                    unique case (r_tail)
                        T_NONE:        n_state = S_FINISH;
                        T_END, T_NL:   n_state = S_PLAN;
                        T_BYTE, T_TU:  n_state = S_CHECK;
                        T_START:       n_state = (seq_len(r_b) != 3'd0) ? S_DISPATCH : S_CHECK;
                        default:       n_state = S_FINISH;
                    endcase
                end
            end
            S_CHECK:    n_state = S_PLAN;
            S_PLAN: begin
                priority if (r_p_flush || r_p_rescan && !r_p_unit && !r_p_nl)
                    n_state = S_RD_ADDR;
                else if (r_p_unit) n_state = S_UNIT;
                else if (r_p_nl)   n_state = S_NL;
                else if (r_p_wr)   n_state = S_WR;
                else               n_state = r_again ? S_CHECK : S_DISPATCH;
            end
            S_RD_ADDR:  n_state = (r_hi == r_hcnt) ? S_PLAN : S_RD_DATA;
            S_RD_DATA:  if (can_emit) n_state = S_RD_ADDR;
            S_UNIT:     if (can_emit && unit_last) n_state = S_PLAN;
            S_NL:       if (can_emit) n_state = S_PLAN;
            S_WR:       if (unit_last) n_state = S_PLAN;
            S_FINISH:   if (!r_lag_v || out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        emit_en     = 1'b0;
        emit_b      = C_NL;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_wdata   = r_u[r_ui];
        finish_push = 1'b0;
        unique case (r_state)
            S_IDLE:    o_q_pop = i_q_valid;
            S_RD_DATA: begin
                emit_en = can_emit;
                emit_b  = ram_rdata;
            end
            S_UNIT: begin
                emit_en = can_emit;
                emit_b  = r_u[r_ui];
            end
            S_NL:      emit_en = can_emit;
            S_WR:      ram_we = 1'b1;
            S_FINISH:  finish_push = r_lag_v && out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tail     <= T_NONE;
            r_col      <= 16'd0;
            r_hcnt     <= '0;
            r_blank    <= 1'b0;
            r_pcnt     <= 2'd0;
            r_pf_n     <= 2'd0;
            r_pf_i     <= 2'd0;
            r_p_flush  <= 1'b0;
            r_p_unit   <= 1'b0;
            r_p_nl     <= 1'b0;
            r_p_rescan <= 1'b0;
            r_p_wr     <= 1'b0;
            r_p_mark   <= 1'b0;
            r_again    <= 1'b0;
            r_rescan   <= 1'b0;
            r_rs_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (i_q_valid) begin
                    r_b    <= i_q_item.data;
                    r_pf_i <= 2'd0;
                    r_pf_n <= 2'd0;
                    if (i_q_item.is_end || i_q_item.is_nl || i_cfg.count_bytes) begin
                        r_pf_n <= r_pcnt;
                        r_pcnt <= 2'd0;
                        r_tail <= i_q_item.is_end ? T_END : (i_q_item.is_nl ? T_NL : T_BYTE);
                    end else if (r_pcnt == 2'd0) begin
                        r_tail <= T_START;
                    end else if (fits_next(r_part[0], r_pcnt, i_q_item.data)) begin
                        if ({1'b0, r_pcnt} + 3'd1 == seq_len(r_part[0])) begin
                            r_u[0] <= r_part[0];
                            r_u[1] <= (r_pcnt == 2'd1) ? i_q_item.data : r_part[1];
                            r_u[2] <= (r_pcnt == 2'd2) ? i_q_item.data : r_part[2];
                            r_u[3] <= i_q_item.data;
                            r_ulen <= {1'b0, r_pcnt} + 3'd1;
                            r_pcnt <= 2'd0;
                            r_tail <= T_TU;
                        end else begin
                            r_part[r_pcnt] <= i_q_item.data;
                            r_pcnt         <= r_pcnt + 2'd1;
                            r_tail         <= T_NONE;
                        end
                    end else begin
                        r_pf_n <= r_pcnt;
                        r_pcnt <= 2'd0;
                        r_tail <= T_START;
                    end
                end
                S_DISPATCH: begin
                    r_again <= 1'b0;
                    if (r_pf_i != r_pf_n) begin
                        r_u[0] <= r_part[r_pf_i];
                        r_ulen <= 3'd1;
                        r_pf_i <= r_pf_i + 2'd1;
                    end else begin
                        r_tail <= T_NONE;
                        unique case (r_tail)
                            T_END: begin
                                r_p_flush <= 1'b1;
                                r_col     <= 16'd0;
                            end
                            T_NL: begin
                                r_p_flush <= 1'b1;
                                r_p_nl    <= 1'b1;
                                r_col     <= 16'd0;
                            end
                            T_BYTE: begin
                                r_u[0] <= r_b;
                                r_ulen <= 3'd1;
                            end
                            T_START: begin
                                if (seq_len(r_b) != 3'd0) begin
                                    r_part[0] <= r_b;
                                    r_pcnt    <= 2'd1;
                                end else begin
                                    r_u[0] <= r_b;
                                    r_ulen <= 3'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CHECK: begin
                    r_again <= 1'b0;
                    if (!blanks_on && r_blank) begin
                        r_p_flush <= 1'b1;
                        r_again   <= 1'b1;
                    end else if (nc > {1'b0, i_cfg.line_width}) begin
                        if (r_col == 16'd0) begin
                            // unit too wide on its own line
                            r_p_flush <= 1'b1;
                            r_p_unit  <= 1'b1;
                            r_p_nl    <= 1'b1;
                        end else begin
                            r_p_nl  <= 1'b1;
                            r_again <= 1'b1;
                            if (r_blank) r_p_rescan <= 1'b1;
                            else         r_col      <= 16'd0;
                        end
                    end else begin
                        r_col <= nc[15:0];
                        if (blanks_on && is_blank) begin
                            r_p_flush <= 1'b1;
                            r_p_unit  <= 1'b1;
                            r_p_mark  <= 1'b1;
                        end else if (r_blank) begin
                            if (fits_hold) begin
                                r_p_wr <= 1'b1;
                            end else begin
                                r_p_flush <= 1'b1;
                                r_p_unit  <= 1'b1;
                            end
                        end else begin
                            r_p_unit <= 1'b1;
                        end
                    end
                end
                S_PLAN: begin
                    r_hi   <= '0;
                    r_ui   <= 2'd0;
                    r_rs_k <= 2'd0;
                    priority if (r_p_flush) begin
                        r_p_flush <= 1'b0;
                        r_rescan  <= 1'b0;
                    end else if (r_p_unit) begin
                        r_p_unit <= 1'b0;
                    end else if (r_p_nl) begin
                        r_p_nl <= 1'b0;
                    end else if (r_p_rescan) begin
                        r_p_rescan <= 1'b0;
                        r_rescan   <= 1'b1;
                        r_col      <= 16'd0;
                    end else if (r_p_wr) begin
                        r_p_wr <= 1'b0;
                    end else if (r_p_mark) begin
                        r_p_mark <= 1'b0;
                        r_blank  <= 1'b1;
                    end
                end
                S_RD_ADDR: if (r_hi == r_hcnt) begin
                    if (r_rescan) r_col <= rs_base;
                    r_hcnt  <= '0;
                    r_blank <= 1'b0;
                end
                S_RD_DATA: if (can_emit) begin
                    r_hi <= r_hi + HW'(1);
                    if (r_rescan) begin
                        if (r_rs_k != 2'd0 && fits_next(r_rs_lead, r_rs_k, ram_rdata)) begin
                            if ({1'b0, r_rs_k} + 3'd1 == r_rs_n) r_rs_k <= 2'd0;
                            else                                 r_rs_k <= r_rs_k + 2'd1;
                        end else begin
                            // broken or no sequence: pending continuation bytes count one each
                            r_col <= rs_nc[15:0];
                            if (seq_len(ram_rdata) != 3'd0) begin
                                r_rs_lead <= ram_rdata;
                                r_rs_n    <= seq_len(ram_rdata);
                                r_rs_k    <= 2'd1;
                            end else begin
                                r_rs_k <= 2'd0;
                            end
                        end
                    end
                end
                S_UNIT: if (can_emit) r_ui <= r_ui + 2'd1;
                S_WR: begin
                    r_ui   <= r_ui + 2'd1;
                    r_hcnt <= r_hcnt + HW'(1);
                end
                default: ;
            endcase
        end
    end

    // one word of lag tells which word closes the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_lag_v <= 1'b0;
        end else if (emit_en) begin
            r_lag_b <= emit_b;
            r_lag_v <= 1'b1;
            if (r_lag_v) begin
                r_ob <= r_lag_b;
                r_ol <= 1'b0;
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end else if (finish_push) begin
            r_ob    <= r_lag_b;
            r_ol    <= 1'b1;
            r_ov    <= 1'b1;
            r_lag_v <= 1'b0;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_byte    = r_ob;
    assign o_out.last_of_run = r_ol;
endmodule

### rtl/text_line_folder_core.sv
// channel | dir | words                           | handshake
// i_in    | in  | action, data_byte               | valid/ready
// o_out   | out | out_byte, last_of_run           | valid/ready
// apb     | in  | line_width, count_bytes, blanks | psel/penable, pready high
//
// a plain byte passes the dispatch, check, plan and unit states of the back end;
// a hold ram byte, sent or rescanned, adds the address and registered read states
// a two-word queue lets input words land while the back end works or stalls
// synchronous active-low reset clears control state; hold ram contents are not cleared
// a stalled output holds its word while the back end may still run one word ahead
module text_line_folder_core
    import tlf_pkg::*;
#(
    parameter int HOLD_DEPTH = 62
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlf_in_if.sink      i_in,
    tlf_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cfg  r_cfg;
    logic  q_valid, q_pop;
    t_item q_item;
    logic  wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width      <= WIDTH_RESET;
            r_cfg.count_bytes     <= 1'b0;
            r_cfg.break_at_blanks <= 1'b0;
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_WIDTH:       r_cfg.line_width      <= pwdata[15:0];
                REG_COUNT_BYTES: r_cfg.count_bytes     <= pwdata[0];
                REG_BLANKS:      r_cfg.break_at_blanks <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:       prdata = {16'd0, r_cfg.line_width};
            REG_COUNT_BYTES: prdata = {31'd0, r_cfg.count_bytes};
            REG_BLANKS:      prdata = {31'd0, r_cfg.break_at_blanks};
            default:         prdata = 32'd0;
        endcase
    end

    tlf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_q_valid(q_valid),
        .o_q_item (q_item),
        .i_q_pop  (q_pop)
    );

    tlf_back #(.HOLD_DEPTH(HOLD_DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_valid(q_valid),
        .i_q_item (q_item),
        .o_q_pop  (q_pop),
        .o_out    (o_out)
    );
endmodule

### rtl/tlf_checker.sv
module tlf_checker
    import tlf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_out_byte,
    input logic        i_psel,
    input logic        i_penable,
    input logic        i_pwrite,
    input logic [3:0]  i_paddr,
    input logic [31:0] i_pwdata,
    input logic [31:0] i_prdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("stalled output word changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_width_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && i_paddr[3:2] == REG_WIDTH
        |=> !(i_psel && !i_pwrite && i_paddr[3:2] == REG_WIDTH) ||
            i_prdata[15:0] == $past(i_pwdata[15:0]))
        else $error("line width readback mismatch");

    a_flag_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && (i_paddr[3:2] == REG_COUNT_BYTES || i_paddr[3:2] == REG_BLANKS)
        |-> i_prdata[31:1] == 31'd0)
        else $error("flag register reads wide");
endmodule

bind text_line_folder_core tlf_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_byte (o_out.out_byte),
    .i_psel     (psel),
    .i_penable  (penable),
    .i_pwrite   (pwrite),
    .i_paddr    (paddr),
    .i_pwdata   (pwdata),
    .i_prdata   (prdata)
);
